// File: rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned IdxW   = 2;   // index of a result within one byte (0..3)
  localparam int unsigned QDepth = 2;   // default depth of the job queue

  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;

  // Byte class masks and patterns
  localparam logic [ByteW-1:0] MaskAscii = 8'h80;
  localparam logic [ByteW-1:0] MaskCont  = 8'hC0;
  localparam logic [ByteW-1:0] PatCont   = 8'h80;
  localparam logic [ByteW-1:0] MaskLead2 = 8'hE0;
  localparam logic [ByteW-1:0] PatLead2  = 8'hC0;
  localparam logic [ByteW-1:0] MaskLead3 = 8'hF0;
  localparam logic [ByteW-1:0] PatLead3  = 8'hE0;
  localparam logic [ByteW-1:0] MaskLead4 = 8'hF8;
  localparam logic [ByteW-1:0] PatLead4  = 8'hF0;
  localparam logic [ByteW-1:0] PayCont   = 8'h3F;
  localparam logic [ByteW-1:0] PayLead2  = 8'h1F;
  localparam logic [ByteW-1:0] PayLead3  = 8'h0F;
  localparam logic [ByteW-1:0] PayLead4  = 8'h07;

  // One classified byte: all results but the last are U+FFFD, the last one
  // carries cp and repl.
  typedef struct packed {
    logic [IdxW-1:0] last_idx;
    logic [CpW-1:0]  cp;
    logic            repl;
    logic            str_end;
  } u8dec_job_t;

endpackage

// File: rtl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to code point decoder.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room and returns code points
// over a valid/ready result channel. The classifier turns each byte into a
// job for a QueueDepth-entry queue; the result sequencer gives one result per
// cycle while results are taken, and a byte yields 0 to 4 results. Well-formed
// text thus runs at one byte per cycle while results are taken, and bytes that
// cause flushes of broken sequences slow intake only while the queue is full.
// Malformed bytes come out as U+FFFD with is_replacement_o set; run_last_o
// marks the last result of a byte and string_done_o the last of a string.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit import u8dec_pkg::*; #(
  parameter int unsigned QueueDepth = QDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             string_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             is_replacement_o,
  output logic             run_last_o,
  output logic             string_done_o
);

  logic       push, pop, full, head_valid;
  u8dec_job_t push_job, head_job;

  assign in_ready_o = ~full;

  u8dec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .string_end_i (string_end_i),
    .push_o       (push),
    .job_o        (push_job)
  );

  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  u8dec_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_job_i       (head_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .run_last_o       (run_last_o),
    .string_done_o    (string_done_o)
  );

endmodule

// File: rtl/u8dec_front.sv
// ----------------------------------------------------------------------------
// u8dec_front
// Byte classifier: tracks the open sequence and turns each byte into a job.
// ----------------------------------------------------------------------------
module u8dec_front import u8dec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             string_end_i,
  output logic             push_o,
  output u8dec_job_t       job_o
);

  logic [1:0]     be_q, be_d;
  logic [1:0]     cc_q, cc_d;
  logic [CpW-1:0] pv_q, pv_d;

  logic           is_open, is_cont;
  logic [2:0]     pre_cnt, cnt;
  logic [1:0]     be_dec, cc_inc;
  logic [CpW-1:0] pv_ext;
  logic           fr_emit, fr_repl;
  logic [CpW-1:0] fr_cp, fr_pv;
  logic [1:0]     fr_be;
  logic           accept;

  assign accept  = in_valid_i & in_ready_i;
  assign is_open = (be_q != 2'd0);
  assign is_cont = ((in_byte_i & MaskCont) == PatCont);
  assign pre_cnt = is_open ? (3'd1 + {1'b0, cc_q}) : 3'd0;
  assign be_dec  = be_q - 2'd1;
  assign cc_inc  = cc_q + 2'd1;
  assign pv_ext  = {pv_q[CpW-7:0], in_byte_i[5:0]};

  // Decode a byte with no sequence open
  always_comb begin
    fr_emit = 1'b0;
    fr_repl = 1'b0;
    fr_cp   = ReplCp;
    fr_pv   = '0;
    fr_be   = 2'd0;
    if ((in_byte_i & MaskAscii) == 8'h00) begin
      fr_emit = 1'b1;
      fr_cp   = {{(CpW-ByteW){1'b0}}, in_byte_i};
    end else if ((in_byte_i & MaskLead2) == PatLead2) begin
      fr_be   = 2'd1;
      fr_pv   = {{(CpW-ByteW){1'b0}}, in_byte_i & PayLead2};
    end else if ((in_byte_i & MaskLead3) == PatLead3) begin
      fr_be   = 2'd2;
      fr_pv   = {{(CpW-ByteW){1'b0}}, in_byte_i & PayLead3};
    end else if ((in_byte_i & MaskLead4) == PatLead4) begin
      fr_be   = 2'd3;
      fr_pv   = {{(CpW-ByteW){1'b0}}, in_byte_i & PayLead4};
    end else begin
      fr_emit = 1'b1;
      fr_repl = 1'b1;
    end
  end

  // Build the job and the next sequence state
  always_comb begin
    be_d          = be_q;
    cc_d          = cc_q;
    pv_d          = pv_q;
    cnt           = 3'd0;
    job_o.cp      = ReplCp;
    job_o.repl    = 1'b1;
    job_o.str_end = string_end_i;
    if (is_open && is_cont) begin
      if (be_dec == 2'd0) begin
        // sequence complete
        cnt        = 3'd1;
        job_o.cp   = pv_ext;
        job_o.repl = 1'b0;
        be_d = 2'd0;
        cc_d = 2'd0;
        pv_d = '0;
      end else if (string_end_i) begin
        // flush lead and all gathered continuations
        cnt  = 3'd1 + {1'b0, cc_inc};
        be_d = 2'd0;
        cc_d = 2'd0;
        pv_d = '0;
      end else begin
        be_d = be_dec;
        cc_d = cc_inc;
        pv_d = pv_ext;
      end
    end else begin
      // flush any broken sequence, then decode afresh
      be_d = 2'd0;
      cc_d = 2'd0;
      pv_d = '0;
      if (fr_emit) begin
        cnt        = pre_cnt + 3'd1;
        job_o.cp   = fr_cp;
        job_o.repl = fr_repl;
      end else if (string_end_i) begin
        cnt = pre_cnt + 3'd1;
      end else begin
        cnt  = pre_cnt;
        be_d = fr_be;
        pv_d = fr_pv;
      end
    end
    job_o.last_idx = cnt[1:0] - 2'd1;
  end

  assign push_o = accept & (cnt != 3'd0);

  // Hold sequence state between bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q <= 2'd0;
      cc_q <= 2'd0;
      pv_q <= '0;
    end else if (accept) begin
      be_q <= be_d;
      cc_q <= cc_d;
      pv_q <= pv_d;
    end
  end

endmodule

// File: rtl/u8dec_queue.sv
// ----------------------------------------------------------------------------
// u8dec_queue
// Short job queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module u8dec_queue import u8dec_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  u8dec_job_t push_job_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output u8dec_job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u8dec_job_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  // Store incoming jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/u8dec_back.sv
// ----------------------------------------------------------------------------
// u8dec_back
// Result sequencer: turns each job into code points, one per unstalled cycle.
// ----------------------------------------------------------------------------
module u8dec_back import u8dec_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  u8dec_job_t     head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           is_replacement_o,
  output logic           run_last_o,
  output logic           string_done_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [CpW-1:0]  cp_q;
  logic            repl_q, last_q, done_q;
  logic            load, at_last;

  assign load    = head_valid_i & (~valid_q | out_ready_i);
  assign at_last = (idx_q == head_job_i.last_idx);
  assign pop_o   = load & at_last;

  // Step through the results of the head job
  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (load) begin
      idx_d = idx_q + 1'b1;
    end
    valid_d = load ? 1'b1 : (valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= at_last ? head_job_i.cp : ReplCp;
      repl_q <= at_last ? head_job_i.repl : 1'b1;
      last_q <= at_last;
      done_q <= at_last & head_job_i.str_end;
    end
  end

  assign out_valid_o      = valid_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = repl_q;
  assign run_last_o       = last_q;
  assign string_done_o    = done_q;

endmodule

// File: rtl/u8dec_checker.sv
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
module u8dec_checker import u8dec_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [ByteW-1:0] in_byte_i,
  input logic             string_end_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CpW-1:0]   code_point_o,
  input logic             is_replacement_o,
  input logic             run_last_o,
  input logic             string_done_o
);

  // Hold a stalled byte
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i)
      && $stable(string_end_i))
    else $error("byte changed while stalled");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o)
      && $stable(is_replacement_o) && $stable(run_last_o) && $stable(string_done_o))
    else $error("result changed while stalled");

  // End of string only on the last result of a byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("string_done without run_last");

  // Substitutions always carry U+FFFD
  a_repl_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_replacement_o |-> code_point_o == ReplCp)
    else $error("replacement with wrong code point");

  // A decoded code point is always the last result of its byte
  a_cp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_replacement_o |-> run_last_o)
    else $error("decoded code point not last of its byte");

endmodule

bind utf8_stream_decoder_unit u8dec_checker u_u8dec_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Feeds byte strings through the input channel and predicts the code points
// each byte completes with an in-bench decoder model. A monitor checks every
// result transfer, in order, against the oldest prediction. Directed strings
// cover ASCII, every sequence length and each malformed case. Random text
// then mixes well-formed sequences with noise, broken and truncated sequences,
// with random idle gaps on both channels except in one back-to-back run.
// ----------------------------------------------------------------------------
module testbench;
  import u8dec_pkg::*;

  localparam int IdleLimit  = 1000;  // cycles without any transfer
  localparam int TailCycles = 20;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           repl;
    logic           last;
    logic           done;
  } cp_result_t;

  logic             clk;
  logic             rst_n;
  logic             byte_valid;
  logic             byte_ready;
  logic [ByteW-1:0] in_byte;
  logic             string_end;
  logic             cp_valid;
  logic             cp_ready;
  logic [CpW-1:0]   code_point;
  logic             is_repl;
  logic             run_last;
  logic             string_done;

  // Decoder model state
  logic [1:0]       dec_need;
  logic [1:0]       dec_got;
  logic [CpW-1:0]   dec_acc;

  cp_result_t       byte_batch[$];
  cp_result_t       expected_cps[$];
  int               err_count;
  int               sent_count;
  int               idle_cycles;
  bit               calm;

  utf8_stream_decoder_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (byte_valid),
    .in_ready_o      (byte_ready),
    .in_byte_i       (in_byte),
    .string_end_i    (string_end),
    .out_valid_o     (cp_valid),
    .out_ready_i     (cp_ready),
    .code_point_o    (code_point),
    .is_replacement_o(is_repl),
    .run_last_o      (run_last),
    .string_done_o   (string_done)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic void push_cp(logic [CpW-1:0] cp, logic repl);
    byte_batch.push_back('{cp: cp, repl: repl, last: 1'b0, done: 1'b0});
  endfunction

  function automatic void clear_open();
    dec_need = '0;
    dec_got  = '0;
    dec_acc  = '0;
  endfunction

  // Replace the open lead and its gathered continuations, one U+FFFD each
  function automatic void flush_open();
    int n;
    n = 1 + dec_got;
    for (int k = 0; k < n; k++) push_cp(ReplCp, 1'b1);
    clear_open();
  endfunction

  function automatic void decode_fresh(logic [ByteW-1:0] b);
    if ((b & MaskAscii) == '0) begin
      push_cp(CpW'(b), 1'b0);
    end else if ((b & MaskLead2) == PatLead2) begin
      dec_need = 2'd1;
      dec_got  = '0;
      dec_acc  = CpW'(b & PayLead2);
    end else if ((b & MaskLead3) == PatLead3) begin
      dec_need = 2'd2;
      dec_got  = '0;
      dec_acc  = CpW'(b & PayLead3);
    end else if ((b & MaskLead4) == PatLead4) begin
      dec_need = 2'd3;
      dec_got  = '0;
      dec_acc  = CpW'(b & PayLead4);
    end else begin
      push_cp(ReplCp, 1'b1);
    end
  endfunction

  // Work out the code points that one accepted byte causes
  function automatic void predict_byte(logic [ByteW-1:0] b, logic e);
    cp_result_t tail;
    byte_batch.delete();
    if (dec_need != '0) begin
      if ((b & MaskCont) == PatCont) begin
        dec_acc  = (dec_acc << 6) | CpW'(b & PayCont);
        dec_got  = dec_got + 2'd1;
        dec_need = dec_need - 2'd1;
        if (dec_need == '0) begin
          push_cp(dec_acc, 1'b0);
          clear_open();
        end
      end else begin
        flush_open();
        decode_fresh(b);
      end
    end else begin
      decode_fresh(b);
    end
    if (e && dec_need != '0) flush_open();
    if (byte_batch.size() > 0) begin
      tail      = byte_batch[byte_batch.size() - 1];
      tail.last = 1'b1;
      tail.done = e;
      byte_batch[byte_batch.size() - 1] = tail;
    end
    foreach (byte_batch[i]) expected_cps.push_back(byte_batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void note_error(string what, cp_result_t want, cp_result_t got);
    err_count++;
    if (err_count <= MaxReports) begin
      $display("[%0t] %s: expected cp=%h repl=%b last=%b done=%b,",
               $realtime, what, want.cp, want.repl, want.last, want.done);
      $display("    got cp=%h repl=%b last=%b done=%b",
               got.cp, got.repl, got.last, got.done);
    end
  endfunction

  function automatic void check_result();
    cp_result_t want;
    cp_result_t got;
    got = '{cp: code_point, repl: is_repl, last: run_last, done: string_done};
    if (expected_cps.size() == 0) begin
      note_error("result with nothing expected", '0, got);
    end else begin
      want = expected_cps.pop_front();
      if (want.cp !== got.cp || want.repl !== got.repl ||
          want.last !== got.last || want.done !== got.done) begin
        note_error("result mismatch", want, got);
      end
    end
  endfunction

  // Predict on each byte transfer, then check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (byte_valid && byte_ready) predict_byte(in_byte, string_end);
      if (cp_valid && cp_ready) check_result();
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (byte_valid && byte_ready) || (cp_valid && cp_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before each transfer
  initial begin : result_sink
    int stall;
    cp_ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        @(negedge clk);
        cp_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      cp_ready <= 1'b1;
      do @(posedge clk); while (!cp_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Idle a random gap, then hold one byte until its transfer
  task automatic send_byte(input logic [ByteW-1:0] b, input logic e);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk);
      byte_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    in_byte    <= b;
    string_end <= e;
    do @(posedge clk); while (!byte_ready);
    sent_count++;
  endtask

  // Hold off the sender until every predicted code point has come out
  task automatic pause_until_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ByteW-1:0] lead_byte(int len);
    case (len)
      1:       lead_byte = ByteW'($urandom_range(0, 127));
      2:       lead_byte = PatLead2 | ByteW'($urandom_range(0, 31));
      3:       lead_byte = PatLead3 | ByteW'($urandom_range(0, 15));
      default: lead_byte = PatLead4 | ByteW'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    cont_byte = PatCont | ByteW'($urandom_range(0, 63));
  endfunction

  // Send a lead of the given length and then conts continuation bytes
  task automatic send_seq(input int len, input int conts, input logic end_last);
    send_byte(lead_byte(len), end_last && conts == 0);
    for (int k = 1; k <= conts; k++) send_byte(cont_byte(), end_last && k == conts);
  endtask

  task automatic test_ascii_passthrough();
    send_byte(8'h00, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte_decode();
    // two-byte, three-byte, and the largest four-byte value
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_malformed_bytes();
    // stray continuation and invalid leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // sequence broken by ASCII
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
    // broken by a new lead that string end then flushes: four results
    send_byte(8'hF0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b1);
    // string end on a lone lead
    send_byte(8'hE2, 1'b1);
  endtask

  // Mostly well-formed text, with noise, broken and truncated sequences
  task automatic test_random_text(input int n_items);
    int stop_at;
    int kind;
    int len;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      if (kind <= 6) begin
        send_seq(len, len - 1, $urandom_range(0, 5) == 0);
      end else if (kind == 7) begin
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if (kind == 8) begin
        len = $urandom_range(2, 4);
        send_seq(len, $urandom_range(0, len - 2), 1'b0);
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        len = $urandom_range(2, 4);
        send_seq(len, $urandom_range(0, len - 2), 1'b1);
      end
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    calm = 1'b1;
    test_random_text(n_items);
    pause_until_drained();
    calm = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    byte_valid = 1'b0;
    in_byte    = '0;
    string_end = 1'b0;
    calm       = 1'b0;
    err_count  = 0;
    sent_count = 0;
    clear_open();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_ascii_passthrough();
    test_multibyte_decode();
    test_malformed_bytes();
    pause_until_drained();
    test_random_text(110);
    pause_until_drained();
    test_back_to_back(65);
    test_random_text(65);
    pause_until_drained();

    repeat (TailCycles) @(posedge clk);
    if (err_count == 0 && expected_cps.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder_unit.f
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_queue.sv
rtl/u8dec_back.sv
rtl/utf8_stream_decoder_unit.sv
rtl/u8dec_checker.sv
bench/testbench.sv
